[sv/klst_pkg.sv]
// Shared types, widths and command codes for the keyed light slot table.
// Used by the controller, the slot memory, the top level and the checker.
// Depends on nothing.
package klst_pkg;

  // Table geometry
  localparam int SLOTS   = 32;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_OUT = 32;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  // Field widths
  localparam int CMD_W   = 2;
  localparam int KEY_W   = 16;
  localparam int POS_W   = 18;
  localparam int RAD_W   = 16;
  localparam int LIFE_W  = 16;
  localparam int DECAY_W = 16;
  localparam int FRAME_W = 10;
  localparam int TIME_W  = 32;
  localparam int OSLOT_W = 5;
  localparam int PROD_W  = FRAME_W + DECAY_W;
  localparam int LOSS_W  = PROD_W - 8;
  localparam int EXT_W   = (SLOT_W > OSLOT_W) ? SLOT_W : OSLOT_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_NEW  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLR  = 2'd3;

  // One slot of the table
  typedef struct packed {
    logic        [KEY_W-1:0]   owner;
    logic        [TIME_W-1:0]  expiry;
    logic        [RAD_W-1:0]   radius;
    logic        [DECAY_W-1:0] decay;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
  } entry_t;

  // Payload of one input item, command excluded
  typedef struct packed {
    logic        [KEY_W-1:0]   key;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic        [RAD_W-1:0]   radius;
    logic        [LIFE_W-1:0]  lifetime_ms;
    logic        [DECAY_W-1:0] decay_rate;
    logic        [FRAME_W-1:0] frame_ms;
  } item_t;

  // One result item
  typedef struct packed {
    logic        [OSLOT_W-1:0] slot;
    logic signed [POS_W-1:0]   out_x;
    logic signed [POS_W-1:0]   out_y;
    logic signed [POS_W-1:0]   out_z;
    logic        [RAD_W-1:0]   out_radius;
    logic                      active;
    logic                      last;
  } result_t;

  // Result handed to the output register
  typedef struct packed {
    logic    vld;
    result_t res;
  } push_t;

  // Memory control group
  typedef struct packed {
    logic              clr;
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
  } mem_req_t;

  // Reported slot number, taken modulo 32
  function automatic logic [OSLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] idx);
    logic [EXT_W-1:0] e;
    e = EXT_W'(idx);
    return e[OSLOT_W-1:0];
  endfunction

endpackage

[sv/klst_mem.sv]
// Slot memory: one write port, one registered read port, one valid bit per slot.
// A slot without its valid bit reads as all zero; clear drops every valid bit.
// Depends on klst_pkg.
module klst_mem (
  input  logic              clk,
  input  logic              rst,
  input  klst_pkg::mem_req_t req,
  input  klst_pkg::entry_t   wdata,
  output klst_pkg::entry_t   rdata
);
  import klst_pkg::*;

  entry_t           mem [SLOTS];
  logic [SLOTS-1:0] valid;
  entry_t           rd_q;
  logic             rd_v;

  // Track written slots
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= wdata;
    end
  end

  // Read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_q <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else if (req.re) begin
      rd_v <= valid[req.raddr];
    end
  end

  assign rdata = rd_v ? rd_q : '0;

endmodule

[sv/klst_ctrl.sv]
// Command sequencer: walks the slot memory one slot a cycle, unless a list
// stalls, for new, tick and list commands, writes back radii and chosen
// slots, and hands results out. Depends on klst_pkg.
module klst_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  output logic                  in_rdy,
  input  logic [klst_pkg::CMD_W-1:0] in_cmd,
  input  klst_pkg::item_t       in_item,
  input  logic                  out_free,
  output klst_pkg::push_t       push,
  output klst_pkg::mem_req_t    req,
  output klst_pkg::entry_t      wdata,
  input  klst_pkg::entry_t      rdata
);
  import klst_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_NEW  = 2'd2;
  localparam logic [1:0] ST_LEND = 2'd3;

  logic [1:0]        state;
  logic [CMD_W-1:0]  cmd_q;
  item_t             item_q;
  logic [TIME_W-1:0] cur_time;
  logic [SLOT_W-1:0] rd_idx;
  logic              rd_done;
  logic              d_vld;
  logic [SLOT_W-1:0] d_idx;
  logic              m_found;
  logic [SLOT_W-1:0] m_idx;
  logic              x_found;
  logic [SLOT_W-1:0] x_idx;
  logic              pend_vld;
  result_t           pend;
  logic [CNT_W-1:0]  cnt;

  logic              accept;
  logic              scanning;
  logic              d_active;
  logic              list_take;
  logic              stall;
  logic              issue;
  logic              proc;
  logic              scan_end;
  logic [SLOT_W-1:0] chosen;
  logic [TIME_W:0]   exp_sum;
  logic [TIME_W-1:0] exp_sat;
  logic [TIME_W:0]   tick_sum;
  logic [PROD_W-1:0] prod;
  logic [LOSS_W-1:0] loss;
  logic [RAD_W-1:0]  new_r;
  result_t           cur_res;

  assign in_rdy   = (state == ST_IDLE);
  assign accept   = in_vld && in_rdy;
  assign scanning = (state == ST_SCAN);
  assign d_active = (rdata.radius != '0);

  // Hold the scan when a listed slot must push out the pending one
  assign list_take = d_vld && (cmd_q == CMD_LIST) && d_active && (cnt < CNT_W'(MAX_OUT));
  assign stall     = scanning && list_take && pend_vld && !out_free;
  assign issue     = scanning && !rd_done && !stall;
  assign proc      = scanning && d_vld && !stall;
  assign scan_end  = scanning && rd_done && !d_vld;

  // Slot choice for a new light
  assign chosen  = m_found ? m_idx : (x_found ? x_idx : '0);
  assign exp_sum = {1'b0, cur_time} + (TIME_W + 1)'(item_q.lifetime_ms);
  assign exp_sat = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

  assign tick_sum = {1'b0, cur_time} + (TIME_W + 1)'(in_item.frame_ms);

  // Decay of the slot just read
  assign prod = PROD_W'(item_q.frame_ms) * PROD_W'(rdata.decay);
  assign loss = prod[PROD_W-1:8];

  always_comb begin
    if (rdata.expiry < cur_time) begin
      new_r = '0;
    end else if (loss >= LOSS_W'(rdata.radius)) begin
      new_r = '0;
    end else begin
      new_r = rdata.radius - loss[RAD_W-1:0];
    end
  end

  // Result view of the slot just read
  always_comb begin
    cur_res.slot       = slot_of(d_idx);
    cur_res.out_x      = rdata.pos_x;
    cur_res.out_y      = rdata.pos_y;
    cur_res.out_z      = rdata.pos_z;
    cur_res.out_radius = rdata.radius;
    cur_res.active     = 1'b1;
    cur_res.last       = 1'b0;
  end

  // Memory requests
  always_comb begin
    req.clr   = accept && (in_cmd == CMD_CLR);
    req.re    = issue;
    req.raddr = rd_idx;
    req.we    = 1'b0;
    req.waddr = d_idx;
    wdata     = rdata;
    wdata.radius = new_r;
    if (state == ST_NEW) begin
      req.we       = out_free;
      req.waddr    = chosen;
      wdata.owner  = item_q.key;
      wdata.expiry = exp_sat;
      wdata.radius = item_q.radius;
      wdata.decay  = item_q.decay_rate;
      wdata.pos_x  = item_q.pos_x;
      wdata.pos_y  = item_q.pos_y;
      wdata.pos_z  = item_q.pos_z;
    end else if (proc && (cmd_q == CMD_TICK) && d_active) begin
      req.we = 1'b1;
    end
  end

  // Results toward the output register
  always_comb begin
    push.vld = 1'b0;
    push.res = pend;
    unique case (state)
      ST_NEW: begin
        push.vld            = out_free;
        push.res.slot       = slot_of(chosen);
        push.res.out_x      = item_q.pos_x;
        push.res.out_y      = item_q.pos_y;
        push.res.out_z      = item_q.pos_z;
        push.res.out_radius = item_q.radius;
        push.res.active     = 1'b1;
        push.res.last       = 1'b1;
      end
      ST_LEND: begin
        push.vld = out_free;
        if (!pend_vld) begin
          push.res = '0;
        end
        push.res.last = 1'b1;
      end
      ST_SCAN: begin
        push.vld = proc && list_take && pend_vld;
      end
      default: begin
        push.vld = 1'b0;
      end
    endcase
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cmd_q    <= CMD_NEW;
      cur_time <= '0;
      rd_idx   <= '0;
      rd_done  <= 1'b0;
      d_vld    <= 1'b0;
      m_found  <= 1'b0;
      x_found  <= 1'b0;
      pend_vld <= 1'b0;
      cnt      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q    <= in_cmd;
            rd_idx   <= '0;
            rd_done  <= 1'b0;
            d_vld    <= 1'b0;
            m_found  <= 1'b0;
            x_found  <= 1'b0;
            pend_vld <= 1'b0;
            cnt      <= '0;
            if (in_cmd == CMD_TICK) begin
              cur_time <= tick_sum[TIME_W] ? '1 : tick_sum[TIME_W-1:0];
            end
            if (in_cmd != CMD_CLR) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // advance the read address
          if (issue) begin
            rd_idx <= SLOT_W'(rd_idx + 1'b1);
            if (rd_idx == SLOT_W'(SLOTS - 1)) begin
              rd_done <= 1'b1;
            end
          end
          if (!stall) begin
            d_vld <= issue;
          end
          // look at the slot just read
          if (proc) begin
            if ((cmd_q == CMD_NEW) && !m_found && (item_q.key != '0) &&
                (rdata.owner == item_q.key)) begin
              m_found <= 1'b1;
            end
            if ((cmd_q == CMD_NEW) && !x_found && (rdata.expiry < cur_time)) begin
              x_found <= 1'b1;
            end
            if (list_take) begin
              pend_vld <= 1'b1;
              cnt      <= cnt + 1'b1;
            end
          end
          if (scan_end) begin
            unique case (cmd_q)
              CMD_NEW:  state <= ST_NEW;
              CMD_LIST: state <= ST_LEND;
              default:  state <= ST_IDLE;
            endcase
          end
        end
        ST_NEW: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_LEND: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= in_item;
    end
    if (issue) begin
      d_idx <= rd_idx;
    end
    if (proc && (cmd_q == CMD_NEW)) begin
      if (!m_found) begin
        m_idx <= d_idx;
      end
      if (!x_found) begin
        x_idx <= d_idx;
      end
    end
    if (proc && list_take) begin
      pend <= cur_res;
    end
  end

endmodule

[sv/keyed_light_slot_table.sv]
// Top level of the keyed light slot table: input unpacking, sequencer, slot
// memory and the output register. Depends on klst_pkg, klst_ctrl, klst_mem.
//
//   channel  dir  tdata (low bit up)                         tuser    tlast
//   s_*      in   key, pos_x, pos_y, pos_z, radius,          cmd      -
//                 lifetime_ms, decay_rate, frame_ms
//   m_*      out  slot, out_x, out_y, out_z, out_radius, 0s  active   last
//
// A tick item is accepted and then walks every slot over the single read port,
// which is registered; a new or list item walks the same way and then hands out
// one final result. A clear item is done on acceptance and leaves the input ready.
// A list stalls its walk, and new and list hold their final result, while the
// output register holds a result that the sink has not taken.
// Reset is synchronous on rst and empties the table at once through per-slot
// valid bits; items are accepted from the first cycle after reset.
module keyed_light_slot_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // key, pos_x, pos_y, pos_z, radius, lifetime_ms, decay_rate, frame_ms
  input  logic [127:0] s_tdata,
  // cmd
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // slot, out_x, out_y, out_z, out_radius, zero fill
  output logic [79:0]  m_tdata,
  // active
  output logic [0:0]   m_tuser,
  output logic         m_tlast
);
  import klst_pkg::*;

  item_t    item;
  push_t    push;
  mem_req_t req;
  entry_t   wdata;
  entry_t   rdata;
  logic     out_free;
  result_t  out_q;

  // Unpack the input item
  assign item.key         = s_tdata[15:0];
  assign item.pos_x       = s_tdata[33:16];
  assign item.pos_y       = s_tdata[51:34];
  assign item.pos_z       = s_tdata[69:52];
  assign item.radius      = s_tdata[85:70];
  assign item.lifetime_ms = s_tdata[101:86];
  assign item.decay_rate  = s_tdata[117:102];
  assign item.frame_ms    = s_tdata[127:118];

  klst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s_tvalid),
    .in_rdy   (s_tready),
    .in_cmd   (s_tuser),
    .in_item  (item),
    .out_free (out_free),
    .push     (push),
    .req      (req),
    .wdata    (wdata),
    .rdata    (rdata)
  );

  klst_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .wdata (wdata),
    .rdata (rdata)
  );

  // Output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= push.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && push.vld) begin
      out_q <= push.res;
    end
  end

  assign m_tdata = {5'b0, out_q.out_radius, out_q.out_z, out_q.out_y, out_q.out_x,
                    out_q.slot};
  assign m_tuser = out_q.active;
  assign m_tlast = out_q.last;

endmodule

[sv/klst_chk.sv]
// Port-level checker for the keyed light slot table, bound to the top level.
// Depends on klst_pkg.
module klst_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [79:0]  m_tdata,
  input logic [0:0]   m_tuser,
  input logic         m_tlast
);
  import klst_pkg::*;

  // A result appears only while a command is being worked
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while the input side was idle");

  // Every command but clear occupies the sequencer
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser != CMD_CLR)) |=> !s_tready)
    else $error("input still ready after a walking command");

  // An empty-list result is all zero and closes the run
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata == '0)))
    else $error("inactive result is not a zero closing result");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind keyed_light_slot_table klst_chk u_chk (.*);

[dv/klst_checker.sv]
`timescale 1ns / 100ps
// Checker for the keyed light slot table: watches both streams, keeps its own
// copy of the slot table and compares every result item. Depends on klst_pkg.
module klst_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // key, pos_x, pos_y, pos_z, radius, lifetime_ms, decay_rate, frame_ms
  input  logic [127:0] s_tdata,
  // cmd
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // slot, out_x, out_y, out_z, out_radius, zero fill
  input  logic [79:0]  m_tdata,
  // active
  input  logic [0:0]   m_tuser,
  input  logic         m_tlast,
  output int           errors,
  output int           pending
);
  import klst_pkg::*;

  // Shadow copy of the table
  logic [TIME_W-1:0]  clock_ms;
  logic [KEY_W-1:0]   own_key    [SLOTS];
  logic [TIME_W-1:0]  expire_at  [SLOTS];
  logic [RAD_W-1:0]   cur_radius [SLOTS];
  logic [DECAY_W-1:0] decay_of   [SLOTS];
  logic [POS_W-1:0]   at_x       [SLOTS];
  logic [POS_W-1:0]   at_y       [SLOTS];
  logic [POS_W-1:0]   at_z       [SLOTS];

  // Result items still owed by the block, oldest first
  result_t light_q[$];
  int      err_count;
  item_t   in_item;
  result_t out_item;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %0s at %0t: got 0x%0h, expected 0x%0h", what, $time, got, want);
    err_count++;
  endtask

  task automatic wipe_lights();
    for (int i = 0; i < SLOTS; i++) begin
      own_key[i]    = '0;
      expire_at[i]  = '0;
      cur_radius[i] = '0;
      decay_of[i]   = '0;
      at_x[i]       = '0;
      at_y[i]       = '0;
      at_z[i]       = '0;
    end
  endtask

  // Key match first, then the first expired slot, else slot 0
  function automatic int pick_slot(input logic [KEY_W-1:0] key);
    int hit;
    hit = -1;
    if (key != '0) begin
      for (int i = 0; i < SLOTS; i++)
        if (hit < 0 && own_key[i] == key) hit = i;
    end
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && expire_at[i] < clock_ms) hit = i;
    if (hit < 0) hit = 0;
    return hit;
  endfunction

  task automatic push_light(input int s, input logic fin);
    result_t r;
    r.slot       = OSLOT_W'(s);
    r.out_x      = at_x[s];
    r.out_y      = at_y[s];
    r.out_z      = at_z[s];
    r.out_radius = cur_radius[s];
    r.active     = 1'b1;
    r.last       = fin;
    light_q.push_back(r);
  endtask

  // Apply one accepted item to the shadow table and queue its results
  task automatic apply_item(input logic [CMD_W-1:0] cmd, input item_t it);
    int                s;
    int                n;
    logic [TIME_W:0]   sum;
    logic [PROD_W-1:0] prod;
    logic [LOSS_W-1:0] loss;
    result_t           r;
    case (cmd)
      CMD_NEW: begin
        s   = pick_slot(it.key);
        sum = {1'b0, clock_ms} + (TIME_W + 1)'(it.lifetime_ms);
        own_key[s]    = it.key;
        at_x[s]       = it.pos_x;
        at_y[s]       = it.pos_y;
        at_z[s]       = it.pos_z;
        cur_radius[s] = it.radius;
        decay_of[s]   = it.decay_rate;
        expire_at[s]  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        push_light(s, 1'b1);
      end
      CMD_TICK: begin
        sum      = {1'b0, clock_ms} + (TIME_W + 1)'(it.frame_ms);
        clock_ms = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        for (int i = 0; i < SLOTS; i++) begin
          if (cur_radius[i] != '0) begin
            if (expire_at[i] < clock_ms) begin
              cur_radius[i] = '0;
            end else begin
              prod = PROD_W'(it.frame_ms) * PROD_W'(decay_of[i]);
              loss = prod[PROD_W-1:8];
              if (loss >= LOSS_W'(cur_radius[i])) cur_radius[i] = '0;
              else cur_radius[i] = cur_radius[i] - RAD_W'(loss);
            end
          end
        end
      end
      CMD_LIST: begin
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (cur_radius[i] != '0 && n < MAX_OUT) begin
            push_light(i, 1'b0);
            n++;
          end
        end
        if (n == 0) begin
          r      = '0;
          r.last = 1'b1;
          light_q.push_back(r);
        end else begin
          r      = light_q.pop_back();
          r.last = 1'b1;
          light_q.push_back(r);
        end
      end
      default: begin
        wipe_lights();
      end
    endcase
  endtask

  // Compare one result item with the oldest one owed
  task automatic check_result(input result_t got);
    result_t want;
    if (light_q.size() == 0) begin
      report_mismatch("result item with none expected", {31'b0, got.last}, 32'b0);
    end else begin
      want = light_q.pop_front();
      if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
      if (got.out_x != want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
      if (got.out_y != want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
      if (got.out_z != want.out_z) report_mismatch("out_z", got.out_z, want.out_z);
      if (got.out_radius != want.out_radius)
        report_mismatch("out_radius", got.out_radius, want.out_radius);
      if (got.active != want.active) report_mismatch("active", got.active, want.active);
      if (got.last != want.last) report_mismatch("last", got.last, want.last);
    end
  endtask

  // Sample both channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      wipe_lights();
      clock_ms  = '0;
      err_count = 0;
      light_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        in_item.key         = s_tdata[15:0];
        in_item.pos_x       = s_tdata[33:16];
        in_item.pos_y       = s_tdata[51:34];
        in_item.pos_z       = s_tdata[69:52];
        in_item.radius      = s_tdata[85:70];
        in_item.lifetime_ms = s_tdata[101:86];
        in_item.decay_rate  = s_tdata[117:102];
        in_item.frame_ms    = s_tdata[127:118];
        apply_item(s_tuser, in_item);
      end
      if (m_tvalid && m_tready) begin
        out_item.slot       = m_tdata[4:0];
        out_item.out_x      = m_tdata[22:5];
        out_item.out_y      = m_tdata[40:23];
        out_item.out_z      = m_tdata[58:41];
        out_item.out_radius = m_tdata[74:59];
        out_item.active     = m_tuser[0];
        out_item.last       = m_tlast;
        check_result(out_item);
      end
    end
    errors  <= err_count;
    pending <= light_q.size();
  end

endmodule

[dv/keyed_light_slot_table_test.sv]
`timescale 1ns / 100ps
// Top of the slot table testbench: clock, reset, command stimulus and the
// verdict. Depends on klst_pkg, keyed_light_slot_table and klst_checker.
module keyed_light_slot_table_test;
  import klst_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // key, pos_x, pos_y, pos_z, radius, lifetime_ms, decay_rate, frame_ms
  logic [127:0] s_tdata;
  // cmd
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  // slot, out_x, out_y, out_z, out_radius, zero fill
  logic [79:0]  m_tdata;
  // active
  logic [0:0]   m_tuser;
  logic         m_tlast;

  int   errors;
  int   pending;
  int   items_sent;
  logic quiet_tail;
  logic hold_req;
  logic hold_done;

  keyed_light_slot_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  klst_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Offer one item, with an optional idle burst before it
  task automatic send_item(input logic [CMD_W-1:0] cmd, input item_t it);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tuser  <= cmd;
    s_tdata  <= {it.frame_ms, it.decay_rate, it.lifetime_ms, it.radius,
                 it.pos_z, it.pos_y, it.pos_x, it.key};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_new(input logic [KEY_W-1:0] key, input logic [POS_W-1:0] x,
                          input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                          input logic [RAD_W-1:0] r, input logic [LIFE_W-1:0] life,
                          input logic [DECAY_W-1:0] decay);
    item_t it;
    it             = '0;
    it.key         = key;
    it.pos_x       = x;
    it.pos_y       = y;
    it.pos_z       = z;
    it.radius      = r;
    it.lifetime_ms = life;
    it.decay_rate  = decay;
    send_item(CMD_NEW, it);
  endtask

  task automatic send_tick(input logic [FRAME_W-1:0] fm);
    item_t it;
    it          = '0;
    it.frame_ms = fm;
    send_item(CMD_TICK, it);
  endtask

  task automatic send_ctl(input logic [CMD_W-1:0] cmd);
    item_t it;
    it = '0;
    send_item(cmd, it);
  endtask

  // Keys drawn from a small pool so that owner matches happen often
  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 5))
      0: return '0;
      4: return '1;
      5: return KEY_W'($urandom);
      default: return KEY_W'($urandom_range(1, 4));
    endcase
  endfunction

  // New light with random position, nonzero radius and mostly slow decay
  task automatic rand_light(input logic [KEY_W-1:0] key, input logic [LIFE_W-1:0] life);
    logic [DECAY_W-1:0] decay;
    decay = ($urandom_range(0, 3) == 0) ? DECAY_W'($urandom)
                                        : DECAY_W'($urandom_range(0, 700));
    send_new(key, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
             RAD_W'($urandom_range(1, 65535)), life, decay);
  endtask

  // Fill every slot, list all of them, then overflow into slot 0
  task automatic fill_table(input logic with_hold);
    send_ctl(CMD_CLR);
    send_tick(FRAME_W'($urandom_range(1, 50)));
    for (int i = 0; i < SLOTS; i++) rand_light('0, LIFE_W'($urandom_range(30000, 65535)));
    if (with_hold) hold_req <= 1'b1;
    send_ctl(CMD_LIST);
    rand_light('0, LIFE_W'($urandom_range(30000, 65535)));
    send_ctl(CMD_LIST);
  endtask

  // Result side: random stalls, one long hold-off, none in the tail
  initial begin
    m_tready  = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (quiet_tail) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Command stimulus and verdict
  initial begin
    int    pick;
    int    rand_end;
    int    fills;
    item_t junk;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = CMD_NEW;
    quiet_tail = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    fills      = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty table lists as a single inactive item
    send_ctl(CMD_LIST);
    // At time zero nothing has expired, so unkeyed lights land in slot 0
    send_new('0, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, '1, '1, '0);
    send_new('1, 18'h20000, 18'h20000, 18'h20000, 16'h0001, '0, '1);
    // Same key again hits its own slot
    send_new('1, 18'h2AAAA, 18'h15555, 18'h00001, 16'h00FF, '0, '1);
    send_tick('0);
    // Zero lifetime expires on the first tick with time moving
    send_tick('1);
    send_ctl(CMD_LIST);
    send_new(16'h1234, 18'h00100, 18'h3FF00, 18'h12345, 16'h8000, 16'd5000, 16'h0100);
    send_new('0, 18'h3FFFF, 18'h00000, 18'h2ABCD, '1, '1, '1);
    send_new(16'hABCD, 18'h0F0F0, 18'h30F0F, 18'h1C3C3, 16'h0010, 16'd100, 16'h1000);
    send_ctl(CMD_LIST);
    // Small decay, large decay and a loss that clamps at zero
    send_tick(10'd1);
    send_ctl(CMD_LIST);
    send_tick(10'd200);
    send_new(16'h1234, 18'h05A5A, 18'h3A5A5, 18'h10000, 16'h7FFF, 16'd60000, 16'h0001);
    // Zero radius is stored but never listed
    send_new('0, 18'h11111, 18'h22222, 18'h33333, '0, 16'd1000, '0);
    send_ctl(CMD_LIST);
    send_ctl(CMD_CLR);
    send_ctl(CMD_LIST);
    // Cleared slots count as expired once time is past zero
    send_new('0, 18'h00001, 18'h3FFFE, 18'h00002, 16'h4321, 16'd2000, 16'h0020);
    send_ctl(CMD_LIST);
    send_tick('1);
    send_ctl(CMD_LIST);

    // Drain before the random part
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    rand_end = items_sent + 185;
    fill_table(1'b1);
    while (items_sent < rand_end) begin
      quiet_tail <= (items_sent >= rand_end - 35);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // Place a few lights, age them a little, list them
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 4) == 0) rand_light(rand_key(), LIFE_W'($urandom));
          else rand_light(rand_key(), LIFE_W'($urandom_range(0, 4000)));
        end
        if ($urandom_range(0, 9) < 7) send_tick(FRAME_W'($urandom_range(0, 40)));
        send_ctl(CMD_LIST);
      end else if (pick < 70 && fills < 1) begin
        fills++;
        fill_table(1'b0);
      end else begin
        // Fully random items of any kind
        repeat ($urandom_range(1, 3)) begin
          junk.key         = KEY_W'($urandom);
          junk.pos_x       = POS_W'($urandom);
          junk.pos_y       = POS_W'($urandom);
          junk.pos_z       = POS_W'($urandom);
          junk.radius      = RAD_W'($urandom);
          junk.lifetime_ms = LIFE_W'($urandom);
          junk.decay_rate  = DECAY_W'($urandom);
          junk.frame_ms    = FRAME_W'($urandom);
          send_item(CMD_W'($urandom), junk);
        end
      end
    end

    // Wait for every owed result, then let the block settle
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[keyed_light_slot_table.f]
sv/klst_pkg.sv
sv/klst_mem.sv
sv/klst_ctrl.sv
sv/keyed_light_slot_table.sv
sv/klst_chk.sv
dv/klst_checker.sv
dv/keyed_light_slot_table_test.sv
